### src/hlp_pkg.sv
// Shared types, codes and helpers for the HTTP header line parser.
`default_nettype none

package hlp_pkg;

  // Result kinds
  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_NAME  = 3'd1;
  localparam logic [2:0] K_VALUE = 3'd2;
  localparam logic [2:0] K_LINE  = 3'd3;
  localparam logic [2:0] K_DONE  = 3'd4;
  localparam logic [2:0] K_ERR   = 3'd5;

  // Character constants
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam int TRIM_W        = 16;
  localparam int COUNT_BITS_DF = 16;
  localparam int QUEUE_DEPTH   = 4;

  // Line parser phase, one-hot
  typedef enum logic [4:0] {
    PH_NAME = 5'b00001,
    PH_LEAD = 5'b00010,
    PH_BODY = 5'b00100,
    PH_DONE = 5'b01000,
    PH_ERR  = 5'b10000
  } phase_t;

  // One accepted byte's results: a first result and an optional value byte
  typedef struct packed {
    logic              two;
    logic [2:0]        kind0;
    logic [7:0]        byte0;
    logic [TRIM_W-1:0] trim0;
    logic [7:0]        byte1;
  } hlp_rec_t;

  // Token characters of a field name
  function automatic logic is_token(input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    if (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) begin
      ok = 1'b1;
    end
    if (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                  8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E}) begin
      ok = 1'b1;
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

### src/hlp_front.sv
// Front end: classifies each input byte and updates the line parser state.
`default_nettype none

module hlp_front import hlp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_of_message,
  output logic            rec_valid,
  output hlp_rec_t        rec
);

  localparam int WIDE_W = (COUNT_BITS > TRIM_W) ? COUNT_BITS : TRIM_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                ph_r, ph_nxt;
  logic                  cr_r, cr_nxt;
  logic                  seen_r, seen_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  phase_t                eph;
  logic                  ecr, eseen;
  logic [COUNT_BITS-1:0] ecnt;
  logic [WIDE_W-1:0]     cnt_wide;
  logic [TRIM_W-1:0]     trim_sat;

  logic                  vb_lead, vb_emit, vb_cr, vb_ws;
  logic [COUNT_BITS-1:0] vb_base, vb_cnt;
  phase_t                vb_ph;

  // Restart at the head of a new header section
  always_comb begin
    if (first_of_message) begin
      eph   = PH_NAME;
      ecr   = 1'b0;
      eseen = 1'b0;
      ecnt  = '0;
    end else begin
      eph   = ph_r;
      ecr   = cr_r;
      eseen = seen_r;
      ecnt  = cnt_r;
    end
  end

  // Saturate the trailing count to the result field
  always_comb begin
    cnt_wide = WIDE_W'(ecnt);
    if (cnt_wide > WIDE_W'({TRIM_W{1'b1}})) begin
      trim_sat = {TRIM_W{1'b1}};
    end else begin
      trim_sat = cnt_wide[TRIM_W-1:0];
    end
  end

  // Handle one value byte (after a held CR that was not a line end, as body)
  always_comb begin
    vb_lead = (eph == PH_LEAD) && !ecr;
    vb_base = ecr ? '0 : ecnt;
    vb_ws   = (data_byte == CH_SP) || (data_byte == CH_TAB);
    vb_emit = 1'b0;
    vb_cr   = 1'b0;
    vb_cnt  = vb_base;
    vb_ph   = ecr ? PH_BODY : eph;
    if (data_byte == CH_CR) begin
      vb_cr = 1'b1;
    end else if (vb_ws && vb_lead) begin
      vb_ph = PH_LEAD;
    end else if (vb_ws) begin
      vb_emit = 1'b1;
      vb_ph   = PH_BODY;
      if (vb_base != CNT_MAX) begin
        vb_cnt = vb_base + 1'b1;
      end
    end else begin
      vb_emit = 1'b1;
      vb_ph   = PH_BODY;
      vb_cnt  = '0;
    end
  end

  // Next state and the results of this byte
  always_comb begin
    ph_nxt    = eph;
    cr_nxt    = ecr;
    seen_nxt  = eseen;
    cnt_nxt   = ecnt;
    rec_valid = 1'b0;
    rec.two   = 1'b0;
    rec.kind0 = K_NONE;
    rec.byte0 = '0;
    rec.trim0 = '0;
    rec.byte1 = data_byte;
    case (eph)
      PH_DONE: begin
        ph_nxt = PH_DONE;
      end
      PH_NAME: begin
        if (ecr) begin
          cr_nxt = 1'b0;
          if (data_byte == CH_LF) begin
            ph_nxt    = PH_DONE;
            rec_valid = 1'b1;
            rec.kind0 = K_DONE;
          end else begin
            ph_nxt = PH_ERR;
          end
        end else if (data_byte == CH_CR && !eseen) begin
          cr_nxt = 1'b1;
        end else if (data_byte == CH_COLON) begin
          if (eseen) begin
            ph_nxt  = PH_LEAD;
            cnt_nxt = '0;
          end else begin
            ph_nxt = PH_ERR;
          end
        end else if (is_token(data_byte)) begin
          seen_nxt  = 1'b1;
          rec_valid = 1'b1;
          rec.kind0 = K_NAME;
          if (data_byte >= CH_UP_A && data_byte <= CH_UP_Z) begin
            rec.byte0 = data_byte + CASE_OFS;
          end else begin
            rec.byte0 = data_byte;
          end
        end else begin
          ph_nxt = PH_ERR;
        end
      end
      PH_LEAD, PH_BODY: begin
        if (ecr && data_byte == CH_LF) begin
          rec_valid = 1'b1;
          rec.kind0 = K_LINE;
          rec.trim0 = trim_sat;
          ph_nxt    = PH_NAME;
          cr_nxt    = 1'b0;
          seen_nxt  = 1'b0;
          cnt_nxt   = '0;
        end else if (ecr) begin
          // Lone CR becomes a value byte, then this byte is a fresh value byte
          rec_valid = 1'b1;
          rec.kind0 = K_VALUE;
          rec.byte0 = CH_CR;
          rec.two   = vb_emit;
          ph_nxt    = vb_ph;
          cr_nxt    = vb_cr;
          cnt_nxt   = vb_cnt;
        end else begin
          rec_valid = vb_emit;
          rec.kind0 = K_VALUE;
          rec.byte0 = data_byte;
          ph_nxt    = vb_ph;
          cr_nxt    = vb_cr;
          cnt_nxt   = vb_cnt;
        end
      end
      default: begin
        ph_nxt = PH_ERR;
      end
    endcase
    // Error is sticky and gives exactly one result per byte
    if (ph_nxt == PH_ERR) begin
      cr_nxt    = 1'b0;
      rec_valid = 1'b1;
      rec.two   = 1'b0;
      rec.kind0 = K_ERR;
      rec.byte0 = '0;
      rec.trim0 = '0;
    end
  end

  // Advance state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_NAME;
      cr_r   <= 1'b0;
      seen_r <= 1'b0;
      cnt_r  <= '0;
    end else if (accept) begin
      ph_r   <= ph_nxt;
      cr_r   <= cr_nxt;
      seen_r <= seen_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### src/hlp_queue.sv
// Short queue of per-byte result records between front and back end.
`default_nettype none

module hlp_queue import hlp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr,
  input  wire hlp_rec_t wr_rec,
  input  wire logic     rd,
  output logic          full,
  output logic          nonempty,
  output hlp_rec_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hlp_rec_t        slot_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign full     = (cnt_r == CW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = slot_r[rp_r];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;

  // Wrap pointers and track fill
  always_comb begin
    wp_nxt  = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    rp_nxt  = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wp_r <= wp_nxt;
      end
      if (do_rd) begin
        rp_r <= rp_nxt;
      end
    end
  end

  // Store records
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_rec;
    end
  end

endmodule

`default_nettype wire

### src/hlp_back.sv
// Back end: expands records into single results held in an output register.
`default_nettype none

module hlp_back import hlp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_nonempty,
  input  wire hlp_rec_t   q_head,
  output logic            q_rd,
  input  wire logic       pop,
  output logic            empty,
  output logic [2:0]      kind,
  output logic [7:0]      out_byte,
  output logic [TRIM_W-1:0] trim_count,
  output logic            last_of_run
);

  logic              valid_r;
  logic              sel_r, sel_nxt;
  logic              load;
  logic [2:0]        kind_r, kind_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [TRIM_W-1:0] trim_r, trim_nxt;
  logic              last_r, last_nxt;

  assign empty       = !valid_r;
  assign kind        = kind_r;
  assign out_byte    = byte_r;
  assign trim_count  = trim_r;
  assign last_of_run = last_r;

  // Refill the output register whenever it is free or being taken
  assign load = q_nonempty && (!valid_r || pop);

  // Pick first or second result of the head record
  always_comb begin
    sel_nxt  = 1'b0;
    q_rd     = 1'b0;
    kind_nxt = q_head.kind0;
    byte_nxt = q_head.byte0;
    trim_nxt = q_head.trim0;
    last_nxt = 1'b1;
    if (sel_r) begin
      kind_nxt = K_VALUE;
      byte_nxt = q_head.byte1;
      trim_nxt = '0;
      q_rd     = load;
    end else if (q_head.two) begin
      last_nxt = 1'b0;
      sel_nxt  = load;
    end else begin
      q_rd = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sel_r   <= sel_nxt;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      trim_r <= trim_nxt;
      last_r <= last_nxt;
    end
  end

  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (kind_r != K_NONE && kind_r <= K_ERR))
    else $error("result register holds an invalid kind");

  a_sel_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (q_nonempty && q_head.two))
    else $error("second result pending without a paired record");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !last_r && pop) |=> (valid_r && kind_r == K_VALUE))
    else $error("second result of a pair not loaded next cycle");

  a_last_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !last_r) |-> sel_r)
    else $error("non-final result shown without its partner pending");

endmodule

`default_nettype wire

### src/http_header_line_parser.sv
// HTTP header field line parser: names lowercased, values trimmed.
// Each result passes through the record queue and the output register to the ports.
// It takes one byte per cycle while the queue is not full; a lone CR in a value
//   followed by a value byte gives two results, which the back end shows in turn.
// The four-record queue between front and back end sets how far each may run ahead.
// Reset (synchronous, rst_n low): name phase, no held CR, count zero, queue empty.
`default_nettype none

module http_header_line_parser import hlp_pkg::*; #(
  parameter int COUNT_BITS  = COUNT_BITS_DF,
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_first_of_message,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic [TRIM_W-1:0] out_trim_count,
  output logic            out_last_of_run
);

  logic     accept;
  logic     rec_valid;
  hlp_rec_t rec;
  logic     q_full, q_nonempty, q_rd;
  hlp_rec_t q_head;

  assign full   = q_full;
  assign accept = push && !q_full;

  hlp_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .first_of_message(in_first_of_message),
    .rec_valid       (rec_valid),
    .rec             (rec)
  );

  hlp_queue #(
    .DEPTH(QUEUE_DEPTH_P)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (accept && rec_valid),
    .wr_rec  (rec),
    .rd      (q_rd),
    .full    (q_full),
    .nonempty(q_nonempty),
    .head    (q_head)
  );

  hlp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .kind       (out_kind),
    .out_byte   (out_byte),
    .trim_count (out_trim_count),
    .last_of_run(out_last_of_run)
  );

endmodule

`default_nettype wire
